/* sv/pfb_segment_deframer_macros.svh */
// ----------------------------------------------------------------------------
// pfb_segment_deframer_macros.svh
// Assertion helpers shared by the deframer checker.
// ----------------------------------------------------------------------------
`ifndef PFB_SEGMENT_DEFRAMER_MACROS_SVH
`define PFB_SEGMENT_DEFRAMER_MACROS_SVH

// Property checked only while out of reset.
`define PSD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define PSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/psd_pkg.sv */
// ----------------------------------------------------------------------------
// psd_pkg
// Types and constants of the segmented font deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package psd_pkg;

	// Segment header marker byte and header size
	localparam logic [7:0] SEG_MARKER   = 8'h80;
	localparam int         HEADER_BYTES = 6;

	// Segment types accepted in a header
	localparam logic [7:0] SEG_TYPE_ASCII  = 8'd1;
	localparam logic [7:0] SEG_TYPE_BINARY = 8'd2;

	// Parser phase
	typedef enum logic [2:0] {
		PH_AWAIT   = 3'd0,
		PH_PASS    = 3'd1,
		PH_MARKER  = 3'd2,
		PH_TYPE    = 3'd3,
		PH_LENGTH  = 3'd4,
		PH_PAYLOAD = 3'd5,
		PH_STOPPED = 3'd6
	} phase_t;

	// Reported status
	typedef enum logic [2:0] {
		ST_DEFRAME = 3'd0,
		ST_PASS    = 3'd1,
		ST_MARKER  = 3'd2,
		ST_TYPE    = 3'd3,
		ST_OVERRUN = 3'd4
	} status_t;

	// One result transaction
	typedef struct packed {
		logic [7:0]  out_byte;
		logic        out_valid;
		logic        file_done;
		status_t     status;
		logic [31:0] payload_count;
	} result_t;

	// Status seen from outside for a given phase
	function automatic status_t phase_status(input phase_t ph, input status_t stop);
		status_t st;
		unique case (ph)
			PH_AWAIT, PH_PASS: st = ST_PASS;
			PH_STOPPED:        st = stop;
			default:           st = ST_DEFRAME;
		endcase
		return st;
	endfunction

endpackage

`default_nettype wire

/* sv/pfb_segment_deframer.sv */
// ----------------------------------------------------------------------------
// pfb_segment_deframer
// Strips segment headers from a segmented font file streamed byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries data_byte and file_start, one
//   file byte per transaction; file_start marks a file's first byte.
//   Program file_length through cfg_wr_en/cfg_wr_data while the block idles.
//   Output channel res_valid/res_ready returns exactly one result per input
//   byte: out_byte/out_valid (payload or not), file_done, status and the
//   running payload_count.
// Timing:
//   Each byte is captured in an input register and parsed from there into
//   the result register, which res_valid/res_ready then presents. One byte
//   is taken per cycle while res_ready is not held low; the per-byte phase
//   update with its 34-bit overrun compare sits in that single stage.
// Reset and stalls:
//   arst_n clears both stages, the parser state and file_length. While the
//   receiver holds res_ready low the result stays put, one more byte waits
//   in the input register and in_ready then drops.
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_segment_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	// input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        file_start,
	// result channel
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic [7:0]       out_byte,
	output logic             out_valid,
	output logic             file_done,
	output logic [2:0]       status,
	output logic [31:0]      payload_count
);

	// configuration register
	logic [31:0] file_length_q;

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;

	// parser state
	psd_pkg::phase_t  phase_q;
	logic [31:0]      position_q;
	logic [1:0]       hidx_q;
	logic [31:0]      remaining_q;
	logic [31:0]      count_q;
	psd_pkg::status_t stop_q;

	// result stage
	logic              valid_s2;
	psd_pkg::result_t  res_s2;

	logic advance;

	// effective state after an optional restart
	psd_pkg::phase_t  eff_phase;
	logic [31:0]      eff_pos;
	logic [1:0]       eff_hidx;
	logic [31:0]      eff_rem;
	logic [31:0]      eff_cnt;
	psd_pkg::status_t eff_stop;

	// next state
	psd_pkg::phase_t  nxt_phase;
	logic [31:0]      nxt_pos;
	logic [1:0]       nxt_hidx;
	logic [31:0]      nxt_rem;
	logic [31:0]      nxt_cnt;
	psd_pkg::status_t nxt_stop;

	logic             beyond;
	logic             last;
	logic             emit;
	logic [31:0]      rem_or;
	logic             seg_overrun;
	psd_pkg::result_t res_d;

	assign advance  = !valid_s2 || res_ready;
	assign in_ready = !valid_s1 || advance;

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= '0;
		end else if (cfg_wr_en) begin
			file_length_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= data_byte;
			start_s1 <= file_start;
		end
	end

	// restart on file_start
	always_comb begin
		if (start_s1) begin
			eff_phase = psd_pkg::PH_AWAIT;
			eff_pos   = '0;
			eff_hidx  = '0;
			eff_rem   = '0;
			eff_cnt   = '0;
			eff_stop  = psd_pkg::ST_DEFRAME;
		end else begin
			eff_phase = phase_q;
			eff_pos   = position_q;
			eff_hidx  = hidx_q;
			eff_rem   = remaining_q;
			eff_cnt   = count_q;
			eff_stop  = stop_q;
		end
	end

	// position checks against the file end
	assign beyond = eff_pos >= file_length_q;
	assign last   = ({1'b0, eff_pos} + 33'd1) == {1'b0, file_length_q};

	// length byte merged into the little-endian segment length
	assign rem_or = eff_rem | ({24'd0, byte_s1} << {eff_hidx, 3'b000});
	assign seg_overrun = ({2'b00, eff_pos} + 34'd1 + {2'b00, rem_or})
		> {2'b00, file_length_q};

	// per-byte parse
	always_comb begin
		nxt_phase = eff_phase;
		nxt_pos   = eff_pos;
		nxt_hidx  = eff_hidx;
		nxt_rem   = eff_rem;
		nxt_cnt   = eff_cnt;
		nxt_stop  = eff_stop;
		emit      = 1'b0;
		if (!beyond) begin
			unique case (eff_phase)
				psd_pkg::PH_AWAIT: begin
					if (byte_s1 != psd_pkg::SEG_MARKER) begin
						nxt_phase = psd_pkg::PH_PASS;
						emit      = 1'b1;
					end else begin
						nxt_phase = psd_pkg::PH_TYPE;
					end
				end
				psd_pkg::PH_PASS: begin
					emit = 1'b1;
				end
				psd_pkg::PH_MARKER: begin
					if (byte_s1 == psd_pkg::SEG_MARKER) begin
						nxt_phase = psd_pkg::PH_TYPE;
					end else begin
						nxt_phase = psd_pkg::PH_STOPPED;
						nxt_stop  = psd_pkg::ST_MARKER;
					end
				end
				psd_pkg::PH_TYPE: begin
					if (byte_s1 == psd_pkg::SEG_TYPE_ASCII ||
						byte_s1 == psd_pkg::SEG_TYPE_BINARY) begin
						nxt_phase = psd_pkg::PH_LENGTH;
						nxt_hidx  = '0;
						nxt_rem   = '0;
					end else begin
						nxt_phase = psd_pkg::PH_STOPPED;
						nxt_stop  = psd_pkg::ST_TYPE;
					end
				end
				psd_pkg::PH_LENGTH: begin
					nxt_rem = rem_or;
					if (eff_hidx == 2'd3) begin
						nxt_hidx = '0;
						if (seg_overrun) begin
							nxt_phase = psd_pkg::PH_STOPPED;
							nxt_stop  = psd_pkg::ST_OVERRUN;
						end else if (rem_or == '0) begin
							nxt_phase = psd_pkg::PH_MARKER;
						end else begin
							nxt_phase = psd_pkg::PH_PAYLOAD;
						end
					end else begin
						nxt_hidx = eff_hidx + 2'd1;
					end
				end
				psd_pkg::PH_PAYLOAD: begin
					emit    = 1'b1;
					nxt_rem = eff_rem - 32'd1;
					if (eff_rem == 32'd1) begin
						nxt_phase = psd_pkg::PH_MARKER;
					end
				end
				default: begin
					nxt_phase = psd_pkg::PH_STOPPED;
				end
			endcase

			// file ends inside a header
			if (last && (nxt_phase == psd_pkg::PH_TYPE ||
				nxt_phase == psd_pkg::PH_LENGTH)) begin
				nxt_phase = psd_pkg::PH_STOPPED;
				nxt_stop  = psd_pkg::ST_OVERRUN;
			end

			if (emit) begin
				nxt_cnt = eff_cnt + 32'd1;
			end
			nxt_pos = eff_pos + 32'd1;
		end
	end

	// result fields
	always_comb begin
		res_d.out_byte      = emit ? byte_s1 : 8'd0;
		res_d.out_valid     = emit;
		res_d.file_done     = !beyond && last;
		res_d.status        = psd_pkg::phase_status(nxt_phase, nxt_stop);
		res_d.payload_count = nxt_cnt;
	end

	// parser state update and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			phase_q     <= psd_pkg::PH_AWAIT;
			position_q  <= '0;
			hidx_q      <= '0;
			remaining_q <= '0;
			count_q     <= '0;
			stop_q      <= psd_pkg::ST_DEFRAME;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				phase_q     <= nxt_phase;
				position_q  <= nxt_pos;
				hidx_q      <= nxt_hidx;
				remaining_q <= nxt_rem;
				count_q     <= nxt_cnt;
				stop_q      <= nxt_stop;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res_d;
		end
	end

	assign res_valid     = valid_s2;
	assign out_byte      = res_s2.out_byte;
	assign out_valid     = res_s2.out_valid;
	assign file_done     = res_s2.file_done;
	assign status        = res_s2.status;
	assign payload_count = res_s2.payload_count;

endmodule

`default_nettype wire

/* sv/psd_checker.sv */
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks of the deframer, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pfb_segment_deframer_macros.svh"

module psd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [7:0]  out_byte,
	input wire logic        out_valid,
	input wire logic        file_done,
	input wire logic [2:0]  status,
	input wire logic [31:0] payload_count
);

	// no result while reset is held
	`PSD_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !res_valid, "result during reset")

	// dropped bytes carry a zero byte
	`PSD_ASSERT(a_drop_zero, clk, arst_n, (res_valid && !out_valid) |-> (out_byte == 8'd0), "dropped byte not zero")

	// payload only while deframing or passing through
	`PSD_ASSERT(a_emit_status, clk, arst_n, (res_valid && out_valid) |-> (status == psd_pkg::ST_DEFRAME || status == psd_pkg::ST_PASS), "payload emitted after stop")

	// stalled result holds
	`PSD_ASSERT(a_stall_hold, clk, arst_n, (res_valid && !res_ready) |=> (res_valid && $stable(out_byte) && $stable(out_valid) && $stable(file_done) && $stable(status) && $stable(payload_count)), "stalled result changed")

endmodule

bind pfb_segment_deframer psd_checker u_psd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res_valid),
	.res_ready     (res_ready),
	.out_byte      (out_byte),
	.out_valid     (out_valid),
	.file_done     (file_done),
	.status        (status),
	.payload_count (payload_count)
);

`default_nettype wire

/* sim/pfb_segment_deframer_tb.sv */
// ----------------------------------------------------------------------------
// pfb_segment_deframer_tb
// Self-checking testbench for the segmented font deframer.
// ----------------------------------------------------------------------------
// A short table of hand-picked bytes walks through passthrough, a clean
// segment, header and segment overruns, bad marker, bad type and bytes past
// the file end. Then random files follow, mostly well-formed segment chains
// with random content and a share of corrupted, truncated and overlong ones.
// Every input transaction is run through a local model of the parser and
// each result transaction is compared field by field in arrival order.
// Both handshake sides idle at random in two phases of pressure, then none idle.
// ----------------------------------------------------------------------------

module pfb_segment_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import psd_pkg::*;

	localparam int DIR_ROWS     = 30;
	localparam int ITEMS_PER_PH = 200;

	// DUT signals
	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte   = '0;
	logic        file_start  = 1'b0;
	logic        res_valid;
	logic        res_ready   = 1'b0;
	logic [7:0]  out_byte;
	logic        out_valid;
	logic        file_done;
	logic [2:0]  status;
	logic [31:0] payload_count;

	pfb_segment_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.file_start    (file_start),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.out_byte      (out_byte),
		.out_valid     (out_valid),
		.file_done     (file_done),
		.status        (status),
		.payload_count (payload_count)
	);

	always #5 clk = ~clk;

	// Parser model state, reset values
	phase_t      m_phase  = PH_AWAIT;
	logic [31:0] m_pos    = '0;
	logic [1:0]  m_hidx   = '0;
	logic [31:0] m_remain = '0;
	logic [31:0] m_count  = '0;
	status_t     m_stop   = ST_DEFRAME;
	logic [31:0] m_len    = '0;

	result_t deframed_q[$];
	int      err_count    = 0;
	int      snd_idle_pct = 7;
	int      rcv_idle_pct = 53;
	int      random_items = 0;

	// Directed stimulus; lit rows carry a typed-in result
	typedef struct packed {
		logic [7:0]  data;
		logic        start;
		logic        set_len;
		logic [31:0] len;
		logic        lit;
		result_t     want;
	} stim_row_t;

	localparam result_t NONE = '{8'h00, 1'b0, 1'b0, ST_DEFRAME, 32'd0};

	stim_row_t dir_table [DIR_ROWS] = '{
		// after reset, zero length: dropped, reported as passthrough
		'{SEG_MARKER, 1'b0, 1'b1, 32'd0, 1'b1, '{8'h00, 1'b0, 1'b0, ST_PASS, 32'd0}},
		// passthrough, no file_start needed after reset
		'{8'h00, 1'b0, 1'b1, 32'd3, 1'b1, '{8'h00, 1'b1, 1'b0, ST_PASS, 32'd1}},
		'{8'hff, 1'b0, 1'b0, 32'd0, 1'b1, '{8'hff, 1'b1, 1'b0, ST_PASS, 32'd2}},
		'{8'h7f, 1'b0, 1'b0, 32'd0, 1'b0, NONE},
		// one-byte segment, file ends where the next header would begin
		'{SEG_MARKER, 1'b1, 1'b1, 32'd7, 1'b0, NONE},
		'{SEG_TYPE_ASCII, 1'b0, 1'b0, 32'd0, 1'b0, NONE},
		'{8'h01, 1'b0, 1'b0, 32'd0, 1'b0, NONE},
		'{8'h00, 1'b0, 1'b0, 32'd0, 1'b0, NONE},
		'{8'h00, 1'b0, 1'b0, 32'd0, 1'b0, NONE},
		'{8'h00, 1'b0, 1'b0, 32'd0, 1'b0, NONE},
		'{8'haa, 1'b0, 1'b0, 32'd0, 1'b0, NONE},
		// file ends right after the marker
		'{SEG_MARKER, 1'b1, 1'b1, 32'd1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OVERRUN, 32'd0}},
		// bad type, then bytes dropped up to and past the end
		'{SEG_MARKER, 1'b1, 1'b1, 32'd3, 1'b0, NONE},
		'{8'h00, 1'b0, 1'b0, 32'd0, 1'b1, '{8'h00, 1'b0, 1'b0, ST_TYPE, 32'd0}},
		'{8'hff, 1'b0, 1'b0, 32'd0, 1'b1, '{8'h00, 1'b0, 1'b1, ST_TYPE, 32'd0}},
		'{8'h01, 1'b0, 1'b0, 32'd0, 1'b1, '{8'h00, 1'b0, 1'b0, ST_TYPE, 32'd0}},
		// empty segment followed by a bad marker
		'{SEG_MARKER, 1'b1, 1'b1, 32'd7, 1'b0, NONE},
		'{SEG_TYPE_BINARY, 1'b0, 1'b0, 32'd0, 1'b0, NONE},
		'{8'h00, 1'b0, 1'b0, 32'd0, 1'b0, NONE},
		'{8'h00, 1'b0, 1'b0, 32'd0, 1'b0, NONE},
		'{8'h00, 1'b0, 1'b0, 32'd0, 1'b0, NONE},
		'{8'h00, 1'b0, 1'b0, 32'd0, 1'b0, NONE},
		'{8'h7f, 1'b0, 1'b0, 32'd0, 1'b1, '{8'h00, 1'b0, 1'b1, ST_MARKER, 32'd0}},
		// segment length far past the file end
		'{SEG_MARKER, 1'b1, 1'b1, 32'd6, 1'b0, NONE},
		'{SEG_TYPE_ASCII, 1'b0, 1'b0, 32'd0, 1'b0, NONE},
		'{8'hff, 1'b0, 1'b0, 32'd0, 1'b0, NONE},
		'{8'hff, 1'b0, 1'b0, 32'd0, 1'b0, NONE},
		'{8'hff, 1'b0, 1'b0, 32'd0, 1'b0, NONE},
		'{8'hff, 1'b0, 1'b0, 32'd0, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OVERRUN, 32'd0}},
		// largest file length
		'{8'h00, 1'b1, 1'b1, 32'hffff_ffff, 1'b1, '{8'h00, 1'b1, 1'b0, ST_PASS, 32'd1}}
	};

	// Status as seen from outside for the model's current phase
	function automatic status_t model_status();
		if (m_phase == PH_AWAIT || m_phase == PH_PASS)
			return ST_PASS;
		if (m_phase == PH_STOPPED)
			return m_stop;
		return ST_DEFRAME;
	endfunction

	// Parse one byte in the model and produce its result
	task automatic deframe_byte(input logic [7:0] b, input logic s, output result_t r);
		logic emit;
		logic last;
		emit = 1'b0;
		if (s) begin
			m_phase  = PH_AWAIT;
			m_pos    = '0;
			m_hidx   = '0;
			m_remain = '0;
			m_count  = '0;
			m_stop   = ST_DEFRAME;
		end
		// past the end: dropped, state untouched
		if (m_pos >= m_len) begin
			r = '{8'h00, 1'b0, 1'b0, model_status(), m_count};
			return;
		end
		last = ({1'b0, m_pos} + 33'd1) == {1'b0, m_len};
		case (m_phase)
			PH_AWAIT: begin
				if (b != SEG_MARKER) begin
					m_phase = PH_PASS;
					emit    = 1'b1;
				end else begin
					m_phase = PH_TYPE;
				end
			end
			PH_PASS: emit = 1'b1;
			PH_MARKER: begin
				if (b == SEG_MARKER) begin
					m_phase = PH_TYPE;
				end else begin
					m_phase = PH_STOPPED;
					m_stop  = ST_MARKER;
				end
			end
			PH_TYPE: begin
				if (b == SEG_TYPE_ASCII || b == SEG_TYPE_BINARY) begin
					m_phase  = PH_LENGTH;
					m_hidx   = '0;
					m_remain = '0;
				end else begin
					m_phase = PH_STOPPED;
					m_stop  = ST_TYPE;
				end
			end
			PH_LENGTH: begin
				m_remain = m_remain | (32'(b) << (8 * m_hidx));
				if (m_hidx == 2'd3) begin
					m_hidx = '0;
					if ({2'b0, m_pos} + 34'd1 + {2'b0, m_remain} > {2'b0, m_len}) begin
						m_phase = PH_STOPPED;
						m_stop  = ST_OVERRUN;
					end else if (m_remain == 0) begin
						m_phase = PH_MARKER;
					end else begin
						m_phase = PH_PAYLOAD;
					end
				end else begin
					m_hidx = m_hidx + 2'd1;
				end
			end
			PH_PAYLOAD: begin
				emit     = 1'b1;
				m_remain = m_remain - 32'd1;
				if (m_remain == 0)
					m_phase = PH_MARKER;
			end
			default: m_phase = PH_STOPPED;
		endcase
		// file ended inside a header
		if (last && (m_phase == PH_TYPE || m_phase == PH_LENGTH)) begin
			m_phase = PH_STOPPED;
			m_stop  = ST_OVERRUN;
		end
		if (emit)
			m_count = m_count + 32'd1;
		m_pos = m_pos + 32'd1;
		r = '{emit ? b : 8'h00, emit, last, model_status(), m_count};
	endtask

	// Drive one input transaction; entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic s, input logic lit,
			input result_t want);
		result_t r;
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		file_start <= s;
		deframe_byte(b, s, r);
		deframed_q.push_back(lit ? want : r);
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Hold off the sender until every pending result has arrived
	task automatic drain_results();
		in_valid <= 1'b0;
		while (deframed_q.size() != 0)
			@(negedge clk);
	endtask

	// Write file_length while the block is idle
	task automatic set_length(input logic [31:0] v);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		m_len = v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Build one random file image, program its length and stream it
	task automatic stream_random_file();
		logic [7:0]  img[$];
		logic [7:0]  b;
		logic [31:0] flen;
		int          kind;
		int          nseg;
		int          slen;
		int          cut;
		int          sub;
		img.delete();
		kind = $urandom_range(99);
		if (kind < 12) begin
			// not segmented
			b = 8'($urandom);
			if (b == SEG_MARKER)
				b = 8'h00;
			img.push_back(b);
			repeat ($urandom_range(11))
				img.push_back(8'($urandom));
		end else begin
			nseg = $urandom_range(1, 3);
			repeat (nseg) begin
				slen = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(6);
				img.push_back(SEG_MARKER);
				img.push_back($urandom_range(1) ? SEG_TYPE_BINARY : SEG_TYPE_ASCII);
				img.push_back(slen[7:0]);
				img.push_back(slen[15:8]);
				img.push_back(slen[23:16]);
				img.push_back(slen[31:24]);
				repeat (slen)
					img.push_back(8'($urandom));
			end
		end
		flen = img.size();
		// broken files: corrupted byte, wrong length, extreme length, garbage
		if (kind >= 12 && kind < 32) begin
			sub = $urandom_range(4);
			case (sub)
				0: img[$urandom_range(img.size() - 1)] = 8'($urandom);
				1: flen = $urandom_range(img.size());
				2: flen = img.size() + $urandom_range(1, 3);
				3: flen = $urandom_range(1) ? 32'hffff_ffff : 32'd0;
				default: begin
					foreach (img[i])
						img[i] = 8'($urandom);
					img[0] = SEG_MARKER;
				end
			endcase
		end
		if ($urandom_range(7) == 0)
			repeat ($urandom_range(1, 3))
				img.push_back(8'($urandom));
		set_length(flen);
		cut = ($urandom_range(9) == 0) ? $urandom_range(img.size() - 1) : -1;
		foreach (img[i]) begin
			// length changed part way through the file
			if (i == cut && i != 0)
				set_length(32'($urandom_range(flen + 2)));
			send_byte(img[i], i == 0 && $urandom_range(9) != 0, 1'b0, NONE);
			if (i < flen)
				random_items++;
		end
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			err_count++;
		end
	endfunction

	// Result receiver idling
	always @(negedge clk)
		res_ready <= ($urandom_range(99) >= rcv_idle_pct);

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && res_valid && res_ready) begin
			if (deframed_q.size() == 0) begin
				$error("result with nothing expected: out_byte %0h status %0d",
					out_byte, status);
				err_count++;
			end else begin
				want = deframed_q.pop_front();
				check_field("out_byte", 32'(want.out_byte), 32'(out_byte));
				check_field("out_valid", 32'(want.out_valid), 32'(out_valid));
				check_field("file_done", 32'(want.file_done), 32'(file_done));
				check_field("status", 32'(want.status), 32'(status));
				check_field("payload_count", want.payload_count, payload_count);
			end
		end
	end

	// Stimulus
	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_table[i].set_len)
				set_length(dir_table[i].len);
			send_byte(dir_table[i].data, dir_table[i].start, dir_table[i].lit,
				dir_table[i].want);
		end

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin snd_idle_pct = 7;  rcv_idle_pct = 53; end
				1: begin snd_idle_pct = 53; rcv_idle_pct = 7;  end
				default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
			endcase
			drain_results();
			while (random_items < ITEMS_PER_PH * (ph + 1))
				stream_random_file();
		end

		drain_results();
		repeat (8) @(negedge clk);
		if (deframed_q.size() != 0) begin
			$error("%0d results never arrived", deframed_q.size());
			err_count++;
		end
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
